### rtl/core/albd_pkg.sv
package albd_pkg;

  // Default frame geometry
  localparam int DefFrameWidth  = 512;
  localparam int DefFrameHeight = 512;

  // Field widths
  localparam int CoordW = 9;
  localparam int ColorW = 24;
  localparam int OpW    = 2;

  // Fixed point: 16 fraction bits on a 9-bit integer part
  localparam int FracW = 16;
  localparam int PosW  = CoordW + FracW;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OpLine  = 2'd0,
    OpRead  = 2'd1,
    OpWrite = 2'd2,
    OpNone  = 2'd3
  } op_e;

  // Blend one RGB888 pixel: per channel (s*(256-a) + c*a) >> 8, clamped to 255
  function automatic logic [ColorW-1:0] blend_px(input logic [ColorW-1:0] src,
                                                 input logic [ColorW-1:0] col,
                                                 input logic [8:0]        wt);
    logic [ColorW-1:0] res;
    logic [8:0]        inv;
    logic [17:0]       acc;
    logic [9:0]        v;
    res = '0;
    inv = 9'd256 - wt;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 18'(src[ch*8 +: 8]) * 18'(inv) + 18'(col[ch*8 +: 8]) * 18'(wt);
      v   = acc[17:8];
      res[ch*8 +: 8] = (v > 10'd255) ? 8'hff : v[7:0];
    end
    return res;
  endfunction

endpackage

### rtl/core/antialiased_line_blend_drawer.sv
// Antialiased line drawer over an RGB888 frame store held in on-chip RAM.
// Input channel (in_valid_i / in_ready_o): one beat is one operation, op_i
// selects draw line, read pixel or write pixel. Output channel
// (out_valid_o / out_ready_i): exactly one beat per operation; read_data_o
// carries the pixel for a read and zero otherwise, done_res_o is always 1.
// Config channel (cfg_valid_i / cfg_ready_o): cfg_data_i sets the draw color;
// write it only while no operation is in flight.
// Operations run one at a time. A line runs a restoring division (both axes
// in parallel) to set up the DDA increments, then walks steps + 1 points,
// steps = max(|dx|,|dy|,1), with states S_P1 and S_P2 for each point, one
// per pixel, and the frame RAM's single read and write port overlapped.
// Read pixel passes through S_PRD, S_PCAP and S_RESP, write pixel through
// S_PWR and S_RESP, the unused op code straight to S_RESP.
// A result waits in the output register while the receiver stalls; the next
// operation is accepted meanwhile and holds in its final cycle until the
// register frees up.
// Reset clears control state and the draw color. The frame RAM is not
// cleared: pixels read before they are written return arbitrary data.
module antialiased_line_blend_drawer #(
  parameter int FrameWidth  = albd_pkg::DefFrameWidth,
  parameter int FrameHeight = albd_pkg::DefFrameHeight
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [albd_pkg::ColorW-1:0] cfg_data_i,
  // operations
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [albd_pkg::OpW-1:0]    op_i,
  input  logic [albd_pkg::CoordW-1:0] start_x_i,
  input  logic [albd_pkg::CoordW-1:0] start_y_i,
  input  logic [albd_pkg::CoordW-1:0] end_x_i,
  input  logic [albd_pkg::CoordW-1:0] end_y_i,
  input  logic [albd_pkg::ColorW-1:0] pixel_value_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [albd_pkg::ColorW-1:0] read_data_o,
  output logic                        done_res_o
);

  localparam int CW     = albd_pkg::CoordW;
  localparam int ColW   = albd_pkg::ColorW;
  localparam int PosW   = albd_pkg::PosW;
  localparam int FracW  = albd_pkg::FracW;
  localparam int Depth  = FrameWidth * FrameHeight;
  localparam int AddrW  = $clog2(Depth);
  localparam int DivCnt = PosW;
  localparam int CntW   = $clog2(DivCnt);
  localparam logic [12:0] WLim = 13'(FrameWidth);
  localparam logic [12:0] HLim = 13'(FrameHeight);

  // Sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV  = 4'd1;
  localparam logic [3:0] S_FIX  = 4'd2;
  localparam logic [3:0] S_P1   = 4'd3;
  localparam logic [3:0] S_P2   = 4'd4;
  localparam logic [3:0] S_PRD  = 4'd5;
  localparam logic [3:0] S_PCAP = 4'd6;
  localparam logic [3:0] S_PWR  = 4'd7;
  localparam logic [3:0] S_RESP = 4'd8;

  logic [3:0]      state_q, state_d;
  logic [ColW-1:0] color_q;

  // Operation registers
  albd_pkg::op_e   op_q;
  logic [CW-1:0]   sx_q, sy_q;
  logic [ColW-1:0] pv_q;
  logic [ColW-1:0] res_q;

  // Line setup and DDA state
  logic [CW-1:0]   steps_q;
  logic            xmaj_q, negx_q, negy_q;
  logic [PosW-1:0] divx_q, divy_q;
  logic [CW-1:0]   remx_q, remy_q;
  logic [CntW-1:0] div_cnt_q;
  logic [PosW-1:0] qx_q, qy_q, dqx_q, dqy_q;
  logic [CW-1:0]   rx_q, ry_q, drx_q, dry_q;
  logic [CW-1:0]   cnt_q;

  // Pending blend write, issued in the cycle after its read
  logic             wr_pend_q;
  logic [AddrW-1:0] wr_addr_q;
  logic [8:0]       wr_wt_q;

  // Frame RAM and forwarding
  logic [ColW-1:0]  frame_mem [Depth];
  logic [ColW-1:0]  rd_data_q;
  logic             fwd_q;
  logic [ColW-1:0]  fwd_data_q;
  logic             mem_we;
  logic [AddrW-1:0] mem_wa, mem_ra;
  logic [ColW-1:0]  mem_wd, src_px, blend_wd;

  logic out_valid_q;
  logic [ColW-1:0] out_data_q;

  function automatic logic [AddrW-1:0] addr_of(input logic [CW:0] x, input logic [CW:0] y);
    return AddrW'(y) * AddrW'(FrameWidth) + AddrW'(x);
  endfunction

  function automatic logic in_frame(input logic [CW:0] x, input logic [CW:0] y);
    return (13'(x) < WLim) && (13'(y) < HLim);
  endfunction

  // Handshakes
  logic in_acc, out_load;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign out_load    = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  // Line setup from the input beat
  logic [CW-1:0] adx, ady, amax;
  always_comb begin
    adx  = (end_x_i >= start_x_i) ? end_x_i - start_x_i : start_x_i - end_x_i;
    ady  = (end_y_i >= start_y_i) ? end_y_i - start_y_i : start_y_i - end_y_i;
    amax = (adx > ady) ? adx : ady;
  end

  // Restoring divider step, both axes
  logic [CW:0]   rsx, rsy;
  logic          gex, gey;
  always_comb begin
    rsx = {remx_q, divx_q[PosW-1]};
    rsy = {remy_q, divy_q[PosW-1]};
    gex = rsx >= {1'b0, steps_q};
    gey = rsy >= {1'b0, steps_q};
  end

  // Signed increment from unsigned quotient and remainder
  logic nzx, nzy;
  assign nzx = (remx_q != '0);
  assign nzy = (remy_q != '0);

  // DDA advance: q += dq, r += dr with carry into q
  logic [CW:0] sumx, sumy;
  logic        wrx, wry;
  always_comb begin
    sumx = {1'b0, rx_q} + {1'b0, drx_q};
    sumy = {1'b0, ry_q} + {1'b0, dry_q};
    wrx  = sumx >= {1'b0, steps_q};
    wry  = sumy >= {1'b0, steps_q};
  end

  // Current point and its two pixels
  logic [CW:0]   px, py, p2x, p2y;
  logic [7:0]    cov;
  always_comb begin
    px  = {1'b0, qx_q[PosW-1:FracW]};
    py  = {1'b0, qy_q[PosW-1:FracW]};
    cov = xmaj_q ? qy_q[FracW-1:8] : qx_q[FracW-1:8];
    p2x = xmaj_q ? px : px + 1'b1;
    p2y = xmaj_q ? py + 1'b1 : py;
  end

  // Memory port control
  assign src_px   = fwd_q ? fwd_data_q : rd_data_q;
  assign blend_wd = albd_pkg::blend_px(src_px, color_q, wr_wt_q);
  always_comb begin
    mem_ra = '0;
    unique case (state_q)
      S_P1:    mem_ra = addr_of(px, py);
      S_P2:    mem_ra = addr_of(p2x, p2y);
      S_PRD:   mem_ra = addr_of({1'b0, sx_q}, {1'b0, sy_q});
      default: mem_ra = '0;
    endcase
    if (state_q == S_PWR) begin
      mem_we = in_frame({1'b0, sx_q}, {1'b0, sy_q});
      mem_wa = addr_of({1'b0, sx_q}, {1'b0, sy_q});
      mem_wd = pv_q;
    end else begin
      mem_we = wr_pend_q;
      mem_wa = wr_addr_q;
      mem_wd = blend_wd;
    end
  end

  // Frame RAM, one read and one write port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_wa] <= mem_wd;
    end
    rd_data_q  <= frame_mem[mem_ra];
    fwd_data_q <= mem_wd;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          unique case (albd_pkg::op_e'(op_i))
            albd_pkg::OpLine:  state_d = S_DIV;
            albd_pkg::OpRead:  state_d = S_PRD;
            albd_pkg::OpWrite: state_d = S_PWR;
            albd_pkg::OpNone:  state_d = S_RESP;
          endcase
        end
      end
      S_DIV:   if (div_cnt_q == CntW'(DivCnt - 1)) state_d = S_FIX;
      S_FIX:   state_d = S_P1;
      S_P1:    state_d = S_P2;
      S_P2:    state_d = (cnt_q == '0) ? S_RESP : S_P1;
      S_PRD:   state_d = S_PCAP;
      S_PCAP:  state_d = S_RESP;
      S_PWR:   state_d = S_RESP;
      S_RESP:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      color_q     <= '0;
      wr_pend_q   <= 1'b0;
      fwd_q       <= 1'b0;
      out_valid_q <= 1'b0;
      div_cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        color_q <= cfg_data_i;
      end
      // a blend write follows each line read, unless the pixel is off frame
      unique case (state_q)
        S_P1:    wr_pend_q <= in_frame(px, py);
        S_P2:    wr_pend_q <= in_frame(p2x, p2y);
        default: wr_pend_q <= 1'b0;
      endcase
      fwd_q <= mem_we && (mem_wa == mem_ra);
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_DIV) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end else begin
        div_cnt_q <= '0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_q    <= albd_pkg::op_e'(op_i);
          sx_q    <= start_x_i;
          sy_q    <= start_y_i;
          pv_q    <= pixel_value_i;
          res_q   <= '0;
          steps_q <= (amax == '0) ? CW'(1) : amax;
          xmaj_q  <= adx > ady;
          negx_q  <= end_x_i < start_x_i;
          negy_q  <= end_y_i < start_y_i;
          divx_q  <= {adx, FracW'(0)};
          divy_q  <= {ady, FracW'(0)};
          remx_q  <= '0;
          remy_q  <= '0;
        end
      end
      S_DIV: begin
        divx_q <= {divx_q[PosW-2:0], gex};
        divy_q <= {divy_q[PosW-2:0], gey};
        remx_q <= gex ? CW'(rsx - {1'b0, steps_q}) : rsx[CW-1:0];
        remy_q <= gey ? CW'(rsy - {1'b0, steps_q}) : rsy[CW-1:0];
      end
      S_FIX: begin
        dqx_q <= negx_q ? PosW'(0) - divx_q - PosW'(nzx) : divx_q;
        dqy_q <= negy_q ? PosW'(0) - divy_q - PosW'(nzy) : divy_q;
        drx_q <= (negx_q && nzx) ? steps_q - remx_q : remx_q;
        dry_q <= (negy_q && nzy) ? steps_q - remy_q : remy_q;
        qx_q  <= {sx_q, FracW'(0)};
        qy_q  <= {sy_q, FracW'(0)};
        rx_q  <= '0;
        ry_q  <= '0;
        cnt_q <= steps_q;
      end
      S_P1: begin
        wr_addr_q <= addr_of(px, py);
        wr_wt_q   <= 9'd256 - {1'b0, cov};
      end
      S_P2: begin
        wr_addr_q <= addr_of(p2x, p2y);
        wr_wt_q   <= {1'b0, cov};
        qx_q      <= qx_q + dqx_q + PosW'(wrx);
        qy_q      <= qy_q + dqy_q + PosW'(wry);
        rx_q      <= wrx ? CW'(sumx - {1'b0, steps_q}) : sumx[CW-1:0];
        ry_q      <= wry ? CW'(sumy - {1'b0, steps_q}) : sumy[CW-1:0];
        cnt_q     <= cnt_q - 1'b1;
      end
      S_PCAP: begin
        res_q <= in_frame({1'b0, sx_q}, {1'b0, sy_q}) ? src_px : '0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_data_q <= (op_q == albd_pkg::OpRead) ? res_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = out_data_q;
  assign done_res_o  = 1'b1;

  // Checks
  a_rem_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_P1) |-> (rx_q < steps_q) && (ry_q < steps_q))
    else $error("DDA remainder out of range");

  a_fwd_needs_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_q |-> $past(mem_we))
    else $error("forwarding without a write");

  a_write_states: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == S_P1 || state_q == S_P2 || state_q == S_RESP ||
                state_q == S_PWR))
    else $error("frame write outside a write phase");

  a_result_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_RESP)
    else $error("result raised outside the response state");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_o)
    else $error("still ready after accepting an operation");

endmodule
